>>> rtl/core/mrbc_pkg.sv
// Shared types, constants and helper functions of the block-code encoder.
package mrbc_pkg;

  localparam int unsigned SYMBOL_W       = 20;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned BUF_W          = 64;
  localparam int unsigned FILL_W         = 7;
  localparam int unsigned SIZE_W         = 3;
  localparam int unsigned NUM_CFG        = 4;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned TIER_W         = 5;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned VALUE_BITS_DEF = 20;
  localparam int unsigned VALUE_BITS_MAX = 24;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [SIZE_W-1:0] SIZE_MIN = 3'd2;
  localparam logic [SIZE_W-1:0] SIZE_MID = 3'd3;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_3 = 2'd3;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol_value;
    logic                end_of_stream;
  } mrbc_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] packed_word;
    logic              final_word;
  } mrbc_out_t;

  // Item after classification in the front part.
  typedef struct packed {
    logic [VALUE_BITS_MAX-1:0] value;
    logic                      is_zero;
    logic                      eos;
  } mrbc_item_t;

  typedef logic [NUM_CFG-1:0][SIZE_W-1:0] mrbc_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DMUL,
    ST_DFIX,
    ST_TAIL,
    ST_EMIT_FULL,
    ST_FLUSH
  } mrbc_state_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] res;
    res = s;
    if (s < SIZE_MIN) res = SIZE_MIN;
    if (s > SIZE_MAX) res = SIZE_MAX;
    return res;
  endfunction

  // Width of block k: configured for the first four blocks, two bits after.
  function automatic logic [SIZE_W-1:0] size_of_block(input logic [TIER_W-1:0] k,
                                                      input mrbc_cfg_t cfg);
    logic [SIZE_W-1:0] res;
    res = SIZE_MIN;
    if (k < TIER_W'(NUM_CFG)) res = clamp_size(cfg[k[CFG_IDX_W-1:0]]);
    return res;
  endfunction

  function automatic logic [DIGIT_W-1:0] base_of(input logic [SIZE_W-1:0] sz);
    logic [DIGIT_W:0] full;
    full = (5'd1 << sz) - 5'd1;
    return full[DIGIT_W-1:0];
  endfunction

endpackage

>>> rtl/core/mrbc_front.sv
// Front part: takes input items, masks and classifies them for the queue.
module mrbc_front #(
  parameter int unsigned VALUE_BITS = mrbc_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrbc_pkg::mrbc_in_t  in_data,
  output logic                push_valid,
  input  logic                push_ready,
  output mrbc_pkg::mrbc_item_t push_item
);

  logic                 hold_valid_r, hold_valid_nxt;
  mrbc_pkg::mrbc_item_t hold_item_r;
  mrbc_pkg::mrbc_item_t classified;
  logic [VALUE_BITS-1:0] masked;

  always_comb begin
    masked             = VALUE_BITS'(in_data.symbol_value);
    classified.value   = mrbc_pkg::VALUE_BITS_MAX'(masked);
    classified.is_zero = (masked == '0);
    classified.eos     = in_data.end_of_stream;
  end

  assign in_ready   = !hold_valid_r || push_ready;
  assign push_valid = hold_valid_r;
  assign push_item  = hold_item_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (push_ready) hold_valid_nxt = 1'b0;
    if (in_valid && in_ready) hold_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item_r <= classified;
    end
  end

endmodule

>>> rtl/core/mrbc_queue.sv
// Two-entry item queue between the front and back parts.
module mrbc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  mrbc_pkg::mrbc_item_t wr_item,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output mrbc_pkg::mrbc_item_t rd_item
);

  localparam int unsigned PTR_W = $clog2(mrbc_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(mrbc_pkg::QUEUE_DEPTH + 1);

  mrbc_pkg::mrbc_item_t entry_r [mrbc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_wr, do_rd;

  assign wr_ready = (count_r != CNT_W'(mrbc_pkg::QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = entry_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) count_nxt = count_r + 1'b1;
    if (!do_wr && do_rd) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

>>> rtl/core/mrbc_back.sv
// Back part: tier search, digit extraction, bit packing and the output register.
module mrbc_back #(
  parameter int unsigned VALUE_BITS = mrbc_pkg::VALUE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mrbc_pkg::mrbc_cfg_t  cfg,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  mrbc_pkg::mrbc_item_t pop_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mrbc_pkg::mrbc_out_t  out_data
);

  localparam int unsigned VB  = VALUE_BITS;
  localparam int unsigned WW  = VALUE_BITS + mrbc_pkg::DIGIT_W;
  localparam int unsigned PW  = 2 * VALUE_BITS;
  localparam int unsigned BW  = mrbc_pkg::BUF_W;
  localparam int unsigned FW  = mrbc_pkg::FILL_W;
  localparam int unsigned TW  = mrbc_pkg::TIER_W;
  localparam int unsigned DW  = mrbc_pkg::DIGIT_W;
  localparam int unsigned WDW = mrbc_pkg::WORD_W;

  // Reciprocals rounded down; the quotient they give is at most one short.
  localparam logic [VB-1:0] RECIP_3  = VB'((64'd1 << VALUE_BITS) / 64'd3);
  localparam logic [VB-1:0] RECIP_7  = VB'((64'd1 << VALUE_BITS) / 64'd7);
  localparam logic [VB-1:0] RECIP_15 = VB'((64'd1 << VALUE_BITS) / 64'd15);

  mrbc_pkg::mrbc_state_t st_r, st_nxt;
  logic [VB-1:0] r_r, r_nxt;
  logic [WW-1:0] w_r, w_nxt;
  logic [TW-1:0] t_r, t_nxt;
  logic [TW-1:0] j_r, j_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [BW-1:0] buf_r, buf_nxt;
  logic          eos_r, eos_nxt;
  logic          out_valid_r, out_valid_nxt;
  mrbc_pkg::mrbc_out_t out_data_r, out_data_nxt;

  logic [mrbc_pkg::SIZE_W-1:0] sz_t, sz_j;
  logic [DW-1:0] base_t, base_j;
  logic [VB-1:0] recip_j;
  logic [VB-1:0] q0;
  logic [WW-1:0] q0_times_base;
  logic [WW-1:0] rem_full;
  logic [DW:0]   rem;
  logic [DW-1:0] digit;
  logic [VB-1:0] quot;
  logic          out_free;

  assign sz_t   = mrbc_pkg::size_of_block(t_r, cfg);
  assign sz_j   = mrbc_pkg::size_of_block(j_r, cfg);
  assign base_t = mrbc_pkg::base_of(sz_t);
  assign base_j = mrbc_pkg::base_of(sz_j);

  always_comb begin
    case (sz_j)
      mrbc_pkg::SIZE_MIN: recip_j = RECIP_3;
      mrbc_pkg::SIZE_MID: recip_j = RECIP_7;
      default:            recip_j = RECIP_15;
    endcase
  end

  // Remainder correction after the reciprocal multiply.
  always_comb begin
    q0            = prod_r[PW-1:VB];
    q0_times_base = (WW'(q0) << sz_j) - WW'(q0);
    rem_full      = WW'(r_r) - q0_times_base;
    rem           = rem_full[DW:0];
    if (rem >= {1'b0, base_j}) begin
      digit = DW'(rem - {1'b0, base_j});
      quot  = q0 + 1'b1;
    end else begin
      digit = rem[DW-1:0];
      quot  = q0;
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign pop_ready = (st_r == mrbc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    st_nxt        = st_r;
    r_nxt         = r_r;
    w_nxt         = w_r;
    t_nxt         = t_r;
    j_nxt         = j_r;
    prod_nxt      = prod_r;
    fill_nxt      = fill_r;
    buf_nxt       = buf_r;
    eos_nxt       = eos_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) out_valid_nxt = 1'b0;

    unique case (st_r)
      mrbc_pkg::ST_IDLE: begin
        if (pop_valid) begin
          r_nxt   = VB'(pop_item.value);
          w_nxt   = WW'(1);
          t_nxt   = '0;
          j_nxt   = '0;
          eos_nxt = pop_item.eos;
          st_nxt  = pop_item.is_zero ? mrbc_pkg::ST_TAIL : mrbc_pkg::ST_SEARCH;
        end
      end
      mrbc_pkg::ST_SEARCH: begin
        if (WW'(r_r) >= w_r) begin
          r_nxt = r_r - VB'(w_r);
          w_nxt = (w_r << sz_t) - w_r;
          t_nxt = t_r + 1'b1;
        end else begin
          st_nxt = (t_r == '0) ? mrbc_pkg::ST_TAIL : mrbc_pkg::ST_DMUL;
        end
      end
      mrbc_pkg::ST_DMUL: begin
        prod_nxt = PW'(r_r) * PW'(recip_j);
        st_nxt   = mrbc_pkg::ST_DFIX;
      end
      mrbc_pkg::ST_DFIX: begin
        buf_nxt  = buf_r | (BW'(digit) << fill_r);
        fill_nxt = fill_r + FW'(sz_j);
        r_nxt    = quot;
        j_nxt    = j_r + 1'b1;
        st_nxt   = (j_r + 1'b1 == t_r) ? mrbc_pkg::ST_TAIL : mrbc_pkg::ST_DMUL;
      end
      mrbc_pkg::ST_TAIL: begin
        buf_nxt  = buf_r | (BW'(base_t) << fill_r);
        fill_nxt = fill_r + FW'(sz_t);
        st_nxt   = mrbc_pkg::ST_EMIT_FULL;
      end
      mrbc_pkg::ST_EMIT_FULL: begin
        if (fill_r >= FW'(WDW)) begin
          if (out_free) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.packed_word = buf_r[WDW-1:0];
            out_data_nxt.final_word  = eos_r && (fill_r == FW'(WDW));
            buf_nxt                  = buf_r >> WDW;
            fill_nxt                 = fill_r - FW'(WDW);
            st_nxt                   = mrbc_pkg::ST_FLUSH;
          end
        end else begin
          st_nxt = mrbc_pkg::ST_FLUSH;
        end
      end
      mrbc_pkg::ST_FLUSH: begin
        if (!eos_r) begin
          st_nxt = mrbc_pkg::ST_IDLE;
        end else if (fill_r == '0) begin
          buf_nxt = '0;
          st_nxt  = mrbc_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.packed_word = buf_r[WDW-1:0];
          out_data_nxt.final_word  = 1'b1;
          buf_nxt                  = '0;
          fill_nxt                 = '0;
          st_nxt                   = mrbc_pkg::ST_IDLE;
        end
      end
      default: st_nxt = mrbc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= mrbc_pkg::ST_IDLE;
      fill_r      <= '0;
      buf_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      fill_r      <= fill_nxt;
      buf_r       <= buf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r        <= r_nxt;
    w_r        <= w_nxt;
    t_r        <= t_nxt;
    j_r        <= j_nxt;
    prod_r     <= prod_nxt;
    eos_r      <= eos_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> rtl/core/mixed_radix_block_code_encoder.sv
// Top level of the block-code encoder: configuration registers and the three parts.
//
// Usage. Each item on the input channel (in_valid, in_ready, in_data) carries one
// unsigned value and an end-of-stream flag. The value is coded as a tier of
// mixed-radix digit blocks closed by an all-ones block, and the code bits are
// packed least significant bit first into 32-bit words on the output channel
// (out_valid, out_ready, out_data). A full word leaves as soon as it is ready;
// on an end-of-stream item any partial word follows zero-padded and marked final.
// Block sizes are written through the configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) while the encoder is idle; cfg_ready is always high.
// The encoder does not itself enforce the idle condition on these writes. An item
// leaves the queue while the back part is idle; its tier is searched, then each digit
// passes through the shared reciprocal multiplier and its correction stage, and last
// the code is closed, any full word is emitted and, at end of stream, the buffer is
// flushed. A zero value skips the search. The tier is at most 15 for 24-bit values.
// Items pass through the classification register and the two-entry queue, which
// keep taking items while the back part works; the back part takes the next item
// only when idle. Reset clears the bit buffer, the fill count, the queue and all
// block sizes to two bits. When the receiver stalls, the finished word is held in the
// output register and the back part waits before writing the next word over it.
module mixed_radix_block_code_encoder #(
  parameter int unsigned VALUE_BITS = mrbc_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mrbc_pkg::mrbc_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mrbc_pkg::mrbc_out_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mrbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mrbc_pkg::SIZE_W-1:0]      cfg_data
);

  mrbc_pkg::mrbc_cfg_t  cfg_r, cfg_nxt;
  logic                 push_valid, push_ready;
  mrbc_pkg::mrbc_item_t push_item;
  logic                 pop_valid, pop_ready;
  mrbc_pkg::mrbc_item_t pop_item;

  // Configuration writes are always taken; sizes are clamped where they are used.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        mrbc_pkg::REG_BLOCK_SIZE_0: cfg_nxt[0] = cfg_data;
        mrbc_pkg::REG_BLOCK_SIZE_1: cfg_nxt[1] = cfg_data;
        mrbc_pkg::REG_BLOCK_SIZE_2: cfg_nxt[2] = cfg_data;
        mrbc_pkg::REG_BLOCK_SIZE_3: cfg_nxt[3] = cfg_data;
        default:                    cfg_nxt    = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= {mrbc_pkg::NUM_CFG{mrbc_pkg::SIZE_MIN}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front part masks the value to VALUE_BITS and flags tier-zero values.
  mrbc_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  mrbc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_item  (pop_item)
  );

  // The back part owns the bit buffer and the output register.
  mrbc_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> bench/tb.sv
// Self-checking testbench of the mixed-radix block-code encoder.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned SYMBOL_W  = mrbc_pkg::SYMBOL_W;
  localparam int unsigned WORD_W    = mrbc_pkg::WORD_W;
  localparam int unsigned NUM_CFG   = mrbc_pkg::NUM_CFG;
  localparam int unsigned CFG_IDX_W = mrbc_pkg::CFG_IDX_W;
  localparam int unsigned SIZE_W    = mrbc_pkg::SIZE_W;

  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned RESET_LEN   = 6;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // The back part works on one item at a time and two more items can sit in its
  // queue, so this settle time covers work that yields no word.
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned TIER_CAP      = 24;
  localparam logic [SYMBOL_W-1:0] SYMBOL_MAX = '1;

  // Block size settings for the sweep, one octal digit per register, with
  // register 0 in the lowest digit. Out-of-range values must be clamped.
  localparam logic [5:0][11:0] SIZE_SWEEP = {
    12'o2222, 12'o4444, 12'o3333, 12'o7510, 12'o6234, 12'o2344
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  mrbc_pkg::mrbc_in_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  mrbc_pkg::mrbc_out_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0]    cfg_data = '0;

  mixed_radix_block_code_encoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block sizes and of the packing state.
  logic [SIZE_W-1:0] shadow_sizes [NUM_CFG];
  logic [63:0]       pending_bits;
  int unsigned       pending_fill;

  // Words the encoder is expected to emit, oldest first.
  mrbc_pkg::mrbc_out_t expected_words [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // The run is cut off as failed once it passes CYCLE_LIMIT, as when the encoder stops making progress.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // A long receiver hold-off counts down here, one step per clock cycle.
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // The receiver stalls at random, or throughout a hold-off.
  always @(negedge clk) begin
    out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // Clamped width of block k; every block after the fourth is two bits wide.
  function automatic int unsigned effective_width(input int unsigned k);
    int unsigned w;
    w = 2;
    if (k < NUM_CFG) begin
      w = shadow_sizes[k];
      if (w < 2) w = 2;
      if (w > 4) w = 4;
    end
    return w;
  endfunction

  // Builds the code of one value: the remainder above the tier's offset in
  // mixed-radix digits, closed by an all-ones block.
  function automatic void build_symbol_code(input logic [SYMBOL_W-1:0] value,
                                            output logic [63:0] code,
                                            output int unsigned code_len);
    logic [63:0] rest;
    logic [63:0] weight;
    logic [63:0] radix;
    int unsigned tier;
    int unsigned shift;
    tier = 0;
    shift = 0;
    rest = 64'(value);
    weight = 64'd1;
    code = '0;
    while (rest >= weight && tier < TIER_CAP) begin
      rest -= weight;
      weight = weight * ((64'd1 << effective_width(tier)) - 64'd1);
      tier++;
    end
    for (int unsigned j = 0; j < tier; j++) begin
      radix = (64'd1 << effective_width(j)) - 64'd1;
      code |= (rest % radix) << shift;
      rest = rest / radix;
      shift += effective_width(j);
    end
    code |= ((64'd1 << effective_width(tier)) - 64'd1) << shift;
    code_len = shift + effective_width(tier);
  endfunction

  // Appends the code of an accepted item and queues the words it completes.
  task automatic predict_words(input mrbc_pkg::mrbc_in_t item);
    logic [63:0] code;
    int unsigned code_len;
    mrbc_pkg::mrbc_out_t word;
    build_symbol_code(item.symbol_value, code, code_len);
    pending_bits |= code << pending_fill;
    pending_fill += code_len;
    if (pending_fill >= WORD_W) begin
      word.packed_word = pending_bits[WORD_W-1:0];
      pending_bits = pending_bits >> WORD_W;
      pending_fill -= WORD_W;
      word.final_word = item.end_of_stream && (pending_fill == 0);
      expected_words.push_back(word);
    end
    if (item.end_of_stream) begin
      // The partial word is flushed with zero padding and the stream restarts.
      if (pending_fill != 0) begin
        word.packed_word = pending_bits[WORD_W-1:0];
        word.final_word = 1'b1;
        expected_words.push_back(word);
      end
      pending_bits = '0;
      pending_fill = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("MISMATCH at cycle %0d: %s got 0x%08h, expected 0x%08h",
             cycle_count, what, got, want);
    error_count++;
  endtask

  // Every word taken from the encoder is compared with the oldest expected word.
  always @(posedge clk) begin
    mrbc_pkg::mrbc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_data.packed_word, '0);
      end else begin
        want = expected_words.pop_front();
        if (out_data.packed_word !== want.packed_word)
          report_mismatch("packed_word", out_data.packed_word, want.packed_word);
        if (out_data.final_word !== want.final_word)
          report_mismatch("final_word", WORD_W'(out_data.final_word),
                          WORD_W'(want.final_word));
      end
    end
  end

  // Offers one item, with the sender idling cycle by cycle at its idle chance,
  // and holds it until it is taken. Valid stays high between back-to-back items.
  task automatic send_symbol(input logic [SYMBOL_W-1:0] value, input logic last);
    mrbc_pkg::mrbc_in_t item;
    item.symbol_value = value;
    item.end_of_stream = last;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    predict_words(item);
  endtask

  // Stops offering items and waits until every expected word has arrived and
  // the encoder has had time to finish work that emits nothing.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [SIZE_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    shadow_sizes[index] = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Writes all four block sizes from one octal setting.
  task automatic write_sizes(input logic [11:0] setting);
    write_register(mrbc_pkg::REG_BLOCK_SIZE_0, setting[2:0]);
    write_register(mrbc_pkg::REG_BLOCK_SIZE_1, setting[5:3]);
    write_register(mrbc_pkg::REG_BLOCK_SIZE_2, setting[8:6]);
    write_register(mrbc_pkg::REG_BLOCK_SIZE_3, setting[11:9]);
  endtask

  // Values spread over small, medium and full ranges so that every tier is hit.
  function automatic logic [SYMBOL_W-1:0] random_symbol();
    logic [SYMBOL_W-1:0] value;
    case ($urandom_range(5))
      0: value = SYMBOL_W'($urandom_range(0, 15));
      1: value = SYMBOL_W'($urandom_range(0, 255));
      2: value = SYMBOL_W'($urandom_range(0, 4095));
      3: value = SYMBOL_MAX - SYMBOL_W'($urandom_range(0, 3));
      default: value = SYMBOL_W'($urandom());
    endcase
    return value;
  endfunction

  // One stretch of streams with random content; the last item always closes
  // its stream so that no bits are left pending.
  task automatic send_random_streams(input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_symbol(random_symbol(), (i == count - 1) || ($urandom_range(7) == 0));
  endtask

  // Tier boundaries, the largest value, an exactly full final word, and a full
  // word followed by a flushed partial word within the same item.
  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_symbol('0, 1'b1);
    send_symbol(SYMBOL_MAX, 1'b1);
    send_symbol(SYMBOL_W'(1), 1'b1);
    send_symbol(SYMBOL_W'(3), 1'b0);
    send_symbol(SYMBOL_W'(4), 1'b1);
    // With two-bit blocks the largest value takes 28 bits, so two zeros fill
    // the word exactly and it leaves marked final.
    send_symbol(SYMBOL_MAX, 1'b0);
    send_symbol('0, 1'b0);
    send_symbol('0, 1'b1);
    // Two largest values overflow the word: one full word, then the rest.
    send_symbol(SYMBOL_MAX, 1'b0);
    send_symbol(SYMBOL_MAX, 1'b1);
    // A word completed mid-stream is not final.
    send_symbol(SYMBOL_MAX, 1'b0);
    send_symbol('0, 1'b0);
    send_symbol('0, 1'b0);
    send_symbol(SYMBOL_W'(12), 1'b1);
    send_symbol(SYMBOL_W'(13), 1'b1);
    send_symbol(SYMBOL_W'(20'h55555), 1'b0);
    send_symbol(SYMBOL_W'(20'haaaaa), 1'b1);
    wait_idle();
  endtask

  // Several block size settings, the extremes and out-of-range values among them.
  task automatic test_block_sizes();
    send_idle_pct = 10;
    recv_stall_pct = 10;
    for (int unsigned s = 0; s < 6; s++) begin
      write_sizes(SIZE_SWEEP[s]);
      send_symbol('0, 1'b0);
      send_symbol(SYMBOL_MAX, 1'b0);
      send_random_streams(35);
      wait_idle();
    end
  endtask

  // The receiver holds off while the sender keeps offering, so the encoder
  // fills up and stalls its input; then the sender pauses for a full drain.
  task automatic test_backpressure();
    write_sizes(12'o2222);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    hold_left = HOLD_CYCLES;
    for (int unsigned i = 0; i < 40; i++)
      send_symbol(SYMBOL_MAX - SYMBOL_W'($urandom_range(0, 255)), i == 39);
    wait_idle();
    send_random_streams(10);
    wait_idle();
    send_random_streams(10);
    wait_idle();
  endtask

  // Long random runs under each idling pattern, with fresh block sizes each time.
  task automatic test_random_phases();
    int unsigned idle_pcts  [4] = '{0, 46, 0, 29};
    int unsigned stall_pcts [4] = '{0, 0, 46, 29};
    for (int unsigned p = 0; p < 4; p++) begin
      write_register(mrbc_pkg::REG_BLOCK_SIZE_0, SIZE_W'($urandom_range(1, 5)));
      write_register(mrbc_pkg::REG_BLOCK_SIZE_1, SIZE_W'($urandom_range(1, 5)));
      write_register(mrbc_pkg::REG_BLOCK_SIZE_2, SIZE_W'($urandom_range(1, 5)));
      write_register(mrbc_pkg::REG_BLOCK_SIZE_3, SIZE_W'($urandom_range(1, 5)));
      send_idle_pct = idle_pcts[p];
      recv_stall_pct = stall_pcts[p];
      send_random_streams(260);
      wait_idle();
    end
  endtask

  initial begin
    for (int k = 0; k < NUM_CFG; k++) shadow_sizes[k] = mrbc_pkg::SIZE_MIN;
    pending_bits = '0;
    pending_fill = 0;
    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_block_sizes();
    test_backpressure();
    test_random_phases();

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/mrbc_pkg.sv
rtl/core/mrbc_front.sv
rtl/core/mrbc_queue.sv
rtl/core/mrbc_back.sv
rtl/core/mixed_radix_block_code_encoder.sv
bench/tb.sv
